// ----- rtl/pbsr_pkg.sv -----
// Shared types and constants for the polled bus slave responder.
package pbsr_pkg;

	localparam int PACKET_BYTES_DEF = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_PKT = 2'd1;
	localparam logic [1:0] KIND_CHK = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [7:0] ACK_BYTE = 8'h20;
	localparam logic [4:0] ADDR_MASK_BITS = 5'h1F;
	localparam logic [1:0] CALL_ACK = 2'b00;
	localparam logic [1:0] CALL_INQ = 2'b10;

	localparam logic [2:0] REG_NODE_ADDRESS = 3'd0;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_ACK,
		OP_INQ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       data_last;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEND,
		ST_CHECK,
		ST_ACK2
	} st_t;

endpackage

// ----- rtl/pbsr_front.sv -----
// Front stage: accepts bus characters and loads and turns them into commands.
module pbsr_front import pbsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [4:0] node_address,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] bus_char,
	input  logic       ninth_bit,
	input  logic       rx_error,
	input  logic [7:0] load_byte,
	input  logic       load_last,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       q_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	logic keep;
	cmd_t cmd_d;
	logic call_ok;

	// A call byte counts only when it is clean, has even parity and carries our address.
	assign call_ok = !rx_error && ninth_bit && !(^bus_char)
		&& ((bus_char[4:0] & ADDR_MASK_BITS) == node_address);

	always_comb begin
		cmd_d.data = load_byte;
		cmd_d.data_last = load_last;
		cmd_d.op = OP_LOAD;
		keep = 1'b0;
		if (mode) begin
			keep = 1'b1;
		end else if (call_ok && bus_char[6:5] == CALL_ACK) begin
			cmd_d.op = OP_ACK;
			keep = 1'b1;
		end else if (call_ok && bus_char[6:5] == CALL_INQ) begin
			cmd_d.op = OP_INQ;
			keep = 1'b1;
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign cmd_valid = valid_s1;
	assign cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// ----- rtl/pbsr_queue.sv -----
// Short command queue between the front and back stages.
module pbsr_queue import pbsr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_cmd,
	output logic full,
	output logic head_valid,
	output cmd_t head_cmd,
	input  logic pop
);

	cmd_t entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = entries[rd_ptr_q];
	assign do_push = push_valid && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/pbsr_back.sv -----
// Back stage: packet buffer, check byte and the result sequencer.
module pbsr_back import pbsr_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] tx_byte,
	output logic       last,
	output logic       load_refused,
	output logic       overflow
);

	localparam int LEN_W = $clog2(PACKET_BYTES + 1);
	localparam int ADDR_W = $clog2(PACKET_BYTES);

	st_t state_q, state_d;
	logic [7:0] mem [PACKET_BYTES];
	logic [7:0] rd_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [7:0] chk_q;
	logic pending_q;

	logic out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] tx_byte_q;
	logic last_q;
	logic refused_q;
	logic overflow_q;

	logic out_free;
	logic out_we;
	logic [1:0] kind_d;
	logic [7:0] tx_byte_d;
	logic last_d;
	logic refused_d;
	logic overflow_d;
	logic mem_we;
	logic rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic clear;
	logic set_pending;
	logic buf_full;

	assign out_free = !out_valid_q || !out_stall;
	assign buf_full = (len_q >= LEN_W'(PACKET_BYTES));

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd_pop = 1'b0;
		out_we = 1'b0;
		kind_d = KIND_STATUS;
		tx_byte_d = '0;
		last_d = 1'b0;
		refused_d = 1'b0;
		overflow_d = 1'b0;
		mem_we = 1'b0;
		rd_en = 1'b0;
		rd_addr = '0;
		clear = 1'b0;
		set_pending = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						OP_LOAD: begin
							out_we = 1'b1;
							kind_d = KIND_STATUS;
							last_d = 1'b1;
							refused_d = pending_q;
							overflow_d = !pending_q && buf_full;
							mem_we = !pending_q && !buf_full;
							set_pending = !pending_q && cmd.data_last;
						end
						OP_ACK: begin
							out_we = 1'b1;
							kind_d = KIND_ACK;
							tx_byte_d = ACK_BYTE;
							state_d = ST_ACK2;
							clear = pending_q;
						end
						OP_INQ: begin
							// A pending packet always holds at least one byte.
							if (pending_q) begin
								rd_en = 1'b1;
								rd_addr = '0;
								idx_d = LEN_W'(1);
								state_d = ST_SEND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SEND: begin
				if (out_free) begin
					out_we = 1'b1;
					kind_d = KIND_PKT;
					tx_byte_d = rd_q;
					if (idx_q == len_q) begin
						state_d = ST_CHECK;
					end else begin
						rd_en = 1'b1;
						rd_addr = idx_q[ADDR_W-1:0];
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ST_CHECK: begin
				if (out_free) begin
					out_we = 1'b1;
					kind_d = KIND_CHK;
					tx_byte_d = chk_q;
					last_d = 1'b1;
					clear = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ACK2: begin
				if (out_free) begin
					out_we = 1'b1;
					kind_d = KIND_ACK;
					tx_byte_d = ACK_BYTE;
					last_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			len_q <= '0;
			chk_q <= '0;
			pending_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			if (clear) begin
				len_q <= '0;
				chk_q <= '0;
				pending_q <= 1'b0;
			end else begin
				if (mem_we) begin
					len_q <= len_q + 1'b1;
					chk_q <= chk_q ^ cmd.data;
				end
				if (set_pending) begin
					pending_q <= 1'b1;
				end
			end
			if (out_we) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[len_q[ADDR_W-1:0]] <= cmd.data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			kind_q <= kind_d;
			tx_byte_q <= tx_byte_d;
			last_q <= last_d;
			refused_q <= refused_d;
			overflow_q <= overflow_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign tx_byte = tx_byte_q;
	assign last = last_q;
	assign load_refused = refused_q;
	assign overflow = overflow_q;

endmodule

// ----- rtl/polled_bus_slave_responder.sv -----
// A load or an acknowledge passes the front register, the queue and the result register; an inquiry
// also passes the packet-buffer read register. A load gives one status result, an acknowledge two
// acknowledge bytes, an inquiry a packet-buffer read setup, each packet byte, then the check byte.
// The back sequencer emits one result per cycle unless stalled; the front drops ignored characters.
// Reset clears node address, packet length, check byte, pending flag and all handshakes;
// the packet buffer is not cleared and holds garbage until loaded.
module polled_bus_slave_responder import pbsr_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  bus_char,
	input  logic        ninth_bit,
	input  logic        rx_error,
	input  logic [7:0]  load_byte,
	input  logic        load_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic        load_refused,
	output logic        overflow
);

	logic [4:0] node_address_q;
	logic front_valid;
	cmd_t front_cmd;
	logic q_full;
	logic head_valid;
	cmd_t head_cmd;
	logic cmd_pop;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_NODE_ADDRESS) ? {27'd0, node_address_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_NODE_ADDRESS) begin
			node_address_q <= pwdata[4:0];
		end
	end

	pbsr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.node_address (node_address_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.bus_char     (bus_char),
		.ninth_bit    (ninth_bit),
		.rx_error     (rx_error),
		.load_byte    (load_byte),
		.load_last    (load_last),
		.cmd_valid    (front_valid),
		.cmd          (front_cmd),
		.q_full       (q_full)
	);

	pbsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_cmd   (front_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (cmd_pop)
	);

	pbsr_back #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (head_valid),
		.cmd          (head_cmd),
		.cmd_pop      (cmd_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.tx_byte      (tx_byte),
		.last         (last),
		.load_refused (load_refused),
		.overflow     (overflow)
	);

endmodule
